// ===== src/pcen_pkg.sv =====
// ----------------------------------------------------------------------------
// pcen_pkg: shared types, constants and step functions
// Register indexes, reset values and the divider and square-root stage steps
// used by the PCEN byte feature core.
// ----------------------------------------------------------------------------
`default_nettype none

package pcen_pkg;

  // Default sizes
  localparam int unsigned Bins       = 64;
  localparam int unsigned SeedFrames = 20;

  // Field widths
  localparam int unsigned BinW    = 6;
  localparam int unsigned EnergyW = 32;
  localparam int unsigned ByteW   = 8;
  localparam int unsigned CfgIdxW = 2;
  localparam int unsigned CfgW    = 32;

  // Configuration register indexes
  localparam logic [CfgIdxW-1:0] CfgSmooth = 2'd0;
  localparam logic [CfgIdxW-1:0] CfgBias   = 2'd1;
  localparam logic [CfgIdxW-1:0] CfgGain   = 2'd2;

  // Configuration reset values
  localparam logic [15:0] SmoothReset = 16'd1638;
  localparam logic [31:0] BiasReset   = 32'd655361;
  localparam logic [15:0] GainReset   = 16'd21760;

  // Q16.16 constants: 2.0 and sqrt(2)
  localparam logic [47:0] TwoQ16   = 48'd131072;
  localparam logic [31:0] Sqrt2Q16 = 32'd92681;

  // Iteration counts of the divider and the root
  localparam int unsigned DivSteps  = 48;
  localparam int unsigned SqrtSteps = 32;

  typedef struct packed {
    logic            v;
    logic            oob;
    logic [BinW-1:0] bin;
    logic [32:0]     rem;
    logic [47:0]     num;
    logic [32:0]     den;
  } div_stage_t;

  typedef struct packed {
    logic            v;
    logic            oob;
    logic [BinW-1:0] bin;
    logic [33:0]     rem;
    logic [31:0]     root;
    logic [63:0]     val;
  } sqrt_stage_t;

  // One restoring division step: bring in a dividend bit, retire a quotient bit
  function automatic div_stage_t div_step(div_stage_t s);
    div_stage_t  r;
    logic [33:0] sh;
    logic        ge;
    r  = s;
    sh = {s.rem, s.num[47]};
    ge = (sh >= {1'b0, s.den});
    r.rem = ge ? 33'(sh - {1'b0, s.den}) : sh[32:0];
    r.num = {s.num[46:0], ge};
    return r;
  endfunction

  // One digit-by-digit root step: bring in two bits, retire one root bit
  function automatic sqrt_stage_t sqrt_step(sqrt_stage_t s);
    sqrt_stage_t r;
    logic [35:0] sh;
    logic [35:0] trial;
    logic        ge;
    r     = s;
    sh    = {s.rem, s.val[63:62]};
    trial = {2'b00, s.root, 2'b01};
    ge    = (sh >= trial);
    r.rem  = ge ? 34'(sh - trial) : sh[33:0];
    r.root = {s.root[30:0], ge};
    r.val  = {s.val[61:0], 2'b00};
    return r;
  endfunction

endpackage

`default_nettype wire

// ===== src/pcen_in_if.sv =====
// ----------------------------------------------------------------------------
// pcen_in_if: input stream channel
// Valid/ready channel that carries one energy item per transaction.
// ----------------------------------------------------------------------------
`default_nettype none

interface pcen_in_if;
  logic                           valid;
  logic                           ready;
  logic                           func;
  logic [pcen_pkg::BinW-1:0]      bin;
  logic [pcen_pkg::EnergyW-1:0]   energy;
  logic                           first_seed;

  modport source (output valid, func, bin, energy, first_seed, input ready);
  modport sink   (input valid, func, bin, energy, first_seed, output ready);
endinterface

`default_nettype wire

// ===== src/pcen_out_if.sv =====
// ----------------------------------------------------------------------------
// pcen_out_if: result stream channel
// Valid/ready channel that carries one feature byte per transaction.
// ----------------------------------------------------------------------------
`default_nettype none

interface pcen_out_if;
  logic                        valid;
  logic                        ready;
  logic [pcen_pkg::ByteW-1:0]  feature_byte;
  logic [pcen_pkg::BinW-1:0]   out_bin;

  modport source (output valid, feature_byte, out_bin, input ready);
  modport sink   (input valid, feature_byte, out_bin, output ready);
endinterface

`default_nettype wire

// ===== src/pcen_u8_feature_core.sv =====
// ----------------------------------------------------------------------------
// pcen_u8_feature_core: per-bin PCEN quantized to one byte
// Seed items build each bin's start value, process items run the smoother,
// the ratio divider and the square root and emit one saturated byte.
// ----------------------------------------------------------------------------
// Pipeline: the result path runs through the 48-stage divider and the 32-stage root
// pipeline (one step per stage).
// Throughput: one transaction per cycle until the output buffer is full; its two
// entries let the input keep going while a result waits.
// Reset: valid bits and per-bin seeded/started flags clear and config registers
// load their reset values at once; the per-bin memory needs no clearing pass.
`default_nettype none

module pcen_u8_feature_core #(
  parameter int unsigned BINS        = pcen_pkg::Bins,
  parameter int unsigned SEED_FRAMES = pcen_pkg::SeedFrames
) (
  input  wire                                 clk_i,
  input  wire                                 rst_ni,
  input  wire                                 cfg_we_i,
  input  wire  [pcen_pkg::CfgIdxW-1:0]        cfg_idx_i,
  input  wire  [pcen_pkg::CfgW-1:0]           cfg_data_i,
  pcen_in_if.sink                             in_i,
  pcen_out_if.source                          out_o
);

  localparam int unsigned IdxW  = (BINS > 1) ? $clog2(BINS) : 1;
  localparam int unsigned RecL  = $clog2(SEED_FRAMES);
  localparam logic [32:0] RecipM = 33'(((64'd1 << (32 + RecL)) / SEED_FRAMES) + 64'd1);
  localparam int unsigned RemW  = $clog2(2 * SEED_FRAMES);
  localparam logic [63:0] SumMax = (64'd1 << 37) - 64'd1;
  localparam logic [36:0] QMax  = 37'(SumMax / SEED_FRAMES);
  localparam logic [RemW-1:0] RMax = RemW'(SumMax % SEED_FRAMES);
  localparam logic [RemW:0]   Sf   = (RemW+1)'(SEED_FRAMES);

  typedef struct packed {
    logic [36:0]     q;
    logic [RemW-1:0] r;
    logic [31:0]     m;
  } bin_word_t;

  // Configuration registers
  logic [15:0] smooth_q, gain_q;
  logic [31:0] bias_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      smooth_q <= pcen_pkg::SmoothReset;
      bias_q   <= pcen_pkg::BiasReset;
      gain_q   <= pcen_pkg::GainReset;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        pcen_pkg::CfgSmooth: smooth_q <= cfg_data_i[15:0];
        pcen_pkg::CfgBias:   bias_q   <= cfg_data_i;
        pcen_pkg::CfgGain:   gain_q   <= cfg_data_i[15:0];
        default: ;
      endcase
    end
  end

  // Pipeline advance: hold everything while the output buffer is full
  logic [1:0] ocnt_q;
  logic       en;
  assign en = (ocnt_q != 2'd2);
  assign in_i.ready = en;

  // Stage 0: capture the transaction
  logic                      s0_v_q, s0_proc_q, s0_first_q;
  logic [pcen_pkg::BinW-1:0] s0_bin_q;
  logic [31:0]               s0_x_q;
  logic [64:0]               s0_prod;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s0_v_q <= 1'b0;
    end else if (en) begin
      s0_v_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s0_proc_q  <= in_i.func;
      s0_first_q <= in_i.first_seed;
      s0_bin_q   <= in_i.bin;
      s0_x_q     <= in_i.energy;
    end
  end

  // Reciprocal multiply for energy / SEED_FRAMES
  assign s0_prod = 65'(s0_x_q) * 65'(RecipM);

  // Stage 1: quotient of the energy, issue the bin read
  logic                      s1_v_q, s1_proc_q, s1_first_q;
  logic [pcen_pkg::BinW-1:0] s1_bin_q;
  logic [31:0]               s1_x_q, s1_qx_q;
  logic [IdxW-1:0]           s1_idx;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q <= 1'b0;
    end else if (en) begin
      s1_v_q <= s0_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s1_proc_q  <= s0_proc_q;
      s1_first_q <= s0_first_q;
      s1_bin_q   <= s0_bin_q;
      s1_x_q     <= s0_x_q;
      s1_qx_q    <= 32'(s0_prod >> (32 + RecL));
    end
  end

  assign s1_idx = IdxW'(s1_bin_q);

  // Per-bin memory and flags
  bin_word_t       mem [BINS];
  logic [BINS-1:0] seeded_q, started_q;
  bin_word_t       rd_q;
  logic            rd_seeded_q, rd_started_q;

  // Last write, forwarded to the next item of the same bin
  logic            lw_v_q, lw_seeded_q, lw_started_q;
  logic [IdxW-1:0] lw_idx_q;
  bin_word_t       lw_word_q;

  // Stage 2 registers
  logic                      s2_v_q, s2_proc_q, s2_first_q;
  logic [pcen_pkg::BinW-1:0] s2_bin_q;
  logic [31:0]               s2_x_q, s2_qx_q;
  logic [IdxW-1:0]           s2_idx;
  logic                      s2_oob;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_v_q <= 1'b0;
    end else if (en) begin
      s2_v_q <= s1_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s2_proc_q    <= s1_proc_q;
      s2_first_q   <= s1_first_q;
      s2_bin_q     <= s1_bin_q;
      s2_x_q       <= s1_x_q;
      s2_qx_q      <= s1_qx_q;
      rd_q         <= mem[s1_idx];
      rd_seeded_q  <= seeded_q[s1_idx];
      rd_started_q <= started_q[s1_idx];
    end
  end

  assign s2_idx = IdxW'(s2_bin_q);
  assign s2_oob = ({3'b000, s2_bin_q} >= 9'(BINS));

  // Stage 2: resolve bin state and update it
  logic                 lw_hit, seeded_f, started_f;
  bin_word_t            fw, wword;
  logic [36:0]          qe;
  logic [RemW-1:0]      re, rx, rn;
  logic [RemW:0]        rs;
  logic                 carry, over;
  logic [37:0]          qs;
  logic [31:0]          m_start, m_cur, m_new;
  logic signed [16:0]   s_sg;
  logic signed [32:0]   dm;
  logic signed [49:0]   pr;
  logic                 w_started;
  logic                 we;

  always_comb begin
    lw_hit    = lw_v_q && (lw_idx_q == s2_idx);
    fw        = lw_hit ? lw_word_q : rd_q;
    seeded_f  = lw_hit ? lw_seeded_q : rd_seeded_q;
    started_f = lw_hit ? lw_started_q : rd_started_q;
    qe        = seeded_f ? fw.q : 37'd0;
    re        = seeded_f ? fw.r : '0;

    // Seed accumulation kept as quotient and remainder by SEED_FRAMES
    rx    = RemW'(s2_x_q - 32'(s2_qx_q * 32'(SEED_FRAMES)));
    rs    = {1'b0, re} + {1'b0, rx};
    carry = (rs >= Sf);
    rn    = carry ? RemW'(rs - Sf) : RemW'(rs);
    qs    = 38'(qe) + 38'(s2_qx_q) + 38'(carry);
    over  = (qs > 38'(QMax)) || ((qs == 38'(QMax)) && (rn > RMax));

    // Smoother: M' = M + floor(s * (x - M) / 2^16)
    m_start = (|qe[36:32]) ? 32'hFFFF_FFFF : qe[31:0];
    m_cur   = started_f ? fw.m : m_start;
    s_sg    = $signed({1'b0, smooth_q});
    dm      = $signed({1'b0, s2_x_q}) - $signed({1'b0, m_cur});
    pr      = 50'(s_sg) * 50'(dm);
    m_new   = m_cur + 32'(pr >>> 16);

    if (s2_proc_q) begin
      wword     = '{q: qe, r: re, m: m_new};
      w_started = 1'b1;
    end else if (s2_first_q) begin
      wword     = '{q: 37'(s2_qx_q), r: rx, m: fw.m};
      w_started = 1'b0;
    end else if (over) begin
      wword     = '{q: QMax, r: RMax, m: fw.m};
      w_started = started_f;
    end else begin
      wword     = '{q: qs[36:0], r: rn, m: fw.m};
      w_started = started_f;
    end

    we = en && s2_v_q && !s2_oob;
  end

  // Write the bin state
  always_ff @(posedge clk_i) begin
    if (we) begin
      mem[s2_idx] <= wword;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seeded_q  <= '0;
      started_q <= '0;
      lw_v_q    <= 1'b0;
    end else if (we) begin
      seeded_q[s2_idx]  <= 1'b1;
      started_q[s2_idx] <= w_started;
      lw_v_q            <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (we) begin
      lw_idx_q     <= s2_idx;
      lw_word_q    <= wword;
      lw_seeded_q  <= 1'b1;
      lw_started_q <= w_started;
    end
  end

  // Stage 3: keep process items only
  logic                      s3_v_q, s3_oob_q;
  logic [pcen_pkg::BinW-1:0] s3_bin_q;
  logic [31:0]               s3_m_q, s3_x_q;
  logic [32:0]               s3_den;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s3_v_q <= 1'b0;
    end else if (en) begin
      s3_v_q <= s2_v_q && s2_proc_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s3_oob_q <= s2_oob;
      s3_bin_q <= s2_bin_q;
      s3_m_q   <= m_new;
      s3_x_q   <= s2_x_q;
    end
  end

  // Divisor, with a zero divisor taken as one LSB
  always_comb begin
    s3_den = 33'(s3_m_q) + 33'(bias_q);
    if (s3_den == 33'd0) begin
      s3_den = 33'd1;
    end
  end

  // Divider pipeline: one quotient bit per stage
  pcen_pkg::div_stage_t div_q [pcen_pkg::DivSteps+1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      div_q[0] <= '0;
    end else if (en) begin
      div_q[0] <= '{v: s3_v_q, oob: s3_oob_q, bin: s3_bin_q, rem: 33'd0,
                    num: {s3_x_q, 16'h0000}, den: s3_den};
    end
  end

  for (genvar k = 0; k < pcen_pkg::DivSteps; k++) begin : g_div
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        div_q[k+1] <= '0;
      end else if (en) begin
        div_q[k+1] <= pcen_pkg::div_step(div_q[k]);
      end
    end
  end

  // Add 2.0 to the ratio and saturate to 48 bits
  logic [48:0] t_sum;
  logic [47:0] t_sat;
  assign t_sum = 49'(div_q[pcen_pkg::DivSteps].num) + 49'(pcen_pkg::TwoQ16);
  assign t_sat = t_sum[48] ? 48'hFFFF_FFFF_FFFF : t_sum[47:0];

  // Root pipeline: one root bit per stage
  pcen_pkg::sqrt_stage_t sq_q [pcen_pkg::SqrtSteps+1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sq_q[0] <= '0;
    end else if (en) begin
      sq_q[0] <= '{v: div_q[pcen_pkg::DivSteps].v, oob: div_q[pcen_pkg::DivSteps].oob,
                   bin: div_q[pcen_pkg::DivSteps].bin, rem: 34'd0, root: 32'd0,
                   val: {t_sat, 16'h0000}};
    end
  end

  for (genvar k = 0; k < pcen_pkg::SqrtSteps; k++) begin : g_sqrt
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        sq_q[k+1] <= '0;
      end else if (en) begin
        sq_q[k+1] <= pcen_pkg::sqrt_step(sq_q[k]);
      end
    end
  end

  // Gain stage: remove sqrt(2) and scale
  logic                      mul_v_q, mul_oob_q;
  logic [pcen_pkg::BinW-1:0] mul_bin_q;
  logic [47:0]               mul_prod_q;
  logic [31:0]               diff;

  assign diff = sq_q[pcen_pkg::SqrtSteps].root - pcen_pkg::Sqrt2Q16;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mul_v_q <= 1'b0;
    end else if (en) begin
      mul_v_q <= sq_q[pcen_pkg::SqrtSteps].v;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      mul_oob_q  <= sq_q[pcen_pkg::SqrtSteps].oob;
      mul_bin_q  <= sq_q[pcen_pkg::SqrtSteps].bin;
      mul_prod_q <= 48'(diff) * 48'(gain_q);
    end
  end

  // Truncate and saturate the byte; an out-of-range bin gives zero
  logic [pcen_pkg::ByteW-1:0] new_byte;
  assign new_byte = mul_oob_q ? 8'd0 : ((|mul_prod_q[47:32]) ? 8'hFF : mul_prod_q[31:24]);

  // Output buffer: two entries, entry 0 drives the port
  logic [pcen_pkg::ByteW-1:0] f0_byte_q, f1_byte_q;
  logic [pcen_pkg::BinW-1:0]  f0_bin_q, f1_bin_q;
  logic                       push, pop;

  assign push = en && mul_v_q;
  assign pop  = out_o.valid && out_o.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ocnt_q <= 2'd0;
    end else begin
      ocnt_q <= 2'(ocnt_q + 2'(push) - 2'(pop));
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop) begin
      if (ocnt_q == 2'd2) begin
        f0_byte_q <= f1_byte_q;
        f0_bin_q  <= f1_bin_q;
        if (push) begin
          f1_byte_q <= new_byte;
          f1_bin_q  <= mul_bin_q;
        end
      end else if (push) begin
        f0_byte_q <= new_byte;
        f0_bin_q  <= mul_bin_q;
      end
    end else if (push) begin
      if (ocnt_q == 2'd0) begin
        f0_byte_q <= new_byte;
        f0_bin_q  <= mul_bin_q;
      end else begin
        f1_byte_q <= new_byte;
        f1_bin_q  <= mul_bin_q;
      end
    end
  end

  assign out_o.valid        = (ocnt_q != 2'd0);
  assign out_o.feature_byte = f0_byte_q;
  assign out_o.out_bin      = f0_bin_q;

endmodule

`default_nettype wire
